>>> sv/tcsnq_pkg.sv
// shared types and constants for the two-channel smooth note quantizer
// used by the front, queue, back and top modules; no dependencies
package tcsnq_pkg;

  localparam int SAMPLE_BITS       = 10;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int ALPHA_BITS        = 16;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET = 16'd655;

  localparam int TRANSPOSE_BITS  = 7;
  localparam int TRANSPOSE_LIMIT = 48;
  localparam int NOTE_BITS       = 7;
  localparam int BRIGHT_BITS     = 8;

  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 40;

  localparam logic [SAMPLE_BITS-1:0] NOTE_LIMIT  = 10'd1000;
  localparam logic [SAMPLE_BITS-1:0] BRIGHT_LOW  = 10'd200;
  localparam logic [SAMPLE_BITS-1:0] BRIGHT_HIGH = 10'd450;

  localparam int SEG_COUNT = 7;
  localparam logic [SAMPLE_BITS-1:0] SEG_UPPER [SEG_COUNT] = '{
    10'd187, 10'd200, 10'd299, 10'd391, 10'd459, 10'd527, 10'd1000
  };
  localparam logic [NOTE_BITS-1:0] SEG_NOTE [SEG_COUNT] = '{
    7'd60, 7'd61, 7'd63, 7'd65, 7'd67, 7'd68, 7'd72
  };

  typedef struct packed {
    logic signed [TRANSPOSE_BITS-1:0] transpose;
    logic [SAMPLE_BITS-1:0]           sample_b;
    logic [SAMPLE_BITS-1:0]           sample_a;
  } item_t;

endpackage

>>> sv/tcsnq_front.sv
// front end: accepts input transfers, detects button edges, tracks transpose
// depends on tcsnq_pkg; feeds items into tcsnq_queue
module tcsnq_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tcsnq_pkg::IN_DATA_BITS-1:0] s_axis_tdata,  // sample_a, sample_b, up, down
  output logic                               push_o,
  input  logic                               push_ready_i,
  output tcsnq_pkg::item_t                   item_o
);

  localparam int SumBits = tcsnq_pkg::TRANSPOSE_BITS + 1;
  localparam int SB      = tcsnq_pkg::SAMPLE_BITS;

  logic signed [tcsnq_pkg::TRANSPOSE_BITS-1:0] tr_q, tr_d;
  logic                                        prev_up_q, prev_down_q;
  logic                                        up, down, accept;
  logic signed [SumBits-1:0]                   sum;

  assign up            = s_axis_tdata[2*SB];
  assign down          = s_axis_tdata[2*SB+1];
  assign s_axis_tready = push_ready_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = accept;

  always_comb begin
    sum = SumBits'(tr_q);
    if (up && !prev_up_q) begin
      sum = sum + SumBits'(1);
    end
    if (down && !prev_down_q) begin
      sum = sum - SumBits'(1);
    end
    if (sum > $signed(SumBits'(tcsnq_pkg::TRANSPOSE_LIMIT))) begin
      tr_d = tcsnq_pkg::TRANSPOSE_BITS'(tcsnq_pkg::TRANSPOSE_LIMIT);
    end else if (sum < -$signed(SumBits'(tcsnq_pkg::TRANSPOSE_LIMIT))) begin
      tr_d = -tcsnq_pkg::TRANSPOSE_BITS'(tcsnq_pkg::TRANSPOSE_LIMIT);
    end else begin
      tr_d = sum[tcsnq_pkg::TRANSPOSE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tr_q        <= '0;
      prev_up_q   <= 1'b0;
      prev_down_q <= 1'b0;
    end else if (accept) begin
      tr_q        <= tr_d;
      prev_up_q   <= up;
      prev_down_q <= down;
    end
  end

  assign item_o.sample_a  = s_axis_tdata[SB-1:0];
  assign item_o.sample_b  = s_axis_tdata[2*SB-1:SB];
  assign item_o.transpose = tr_d;

endmodule

>>> sv/tcsnq_queue.sv
// two-entry queue decoupling the front end from the back end
// depends on tcsnq_pkg for the item type
module tcsnq_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  tcsnq_pkg::item_t wr_item_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output tcsnq_pkg::item_t rd_item_o
);

  tcsnq_pkg::item_t mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             wr_en, rd_en;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd_en) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (wr_en && !rd_en) begin
        count_q <= count_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sv/tcsnq_back.sv
// back end: exponential smoothing, note lookup, brightness and output register
// depends on tcsnq_pkg; takes items from tcsnq_queue
module tcsnq_back #(
  parameter int FRACTION_BITS = tcsnq_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [tcsnq_pkg::ALPHA_BITS-1:0]    alpha_i,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  tcsnq_pkg::item_t                    item_i,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // note_valid, note, level_b_out, brightness_a, brightness_b
  output logic [tcsnq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  localparam int SB   = tcsnq_pkg::SAMPLE_BITS;
  localparam int AB   = tcsnq_pkg::ALPHA_BITS;
  localparam int LW   = SB + FRACTION_BITS;
  localparam int PW   = LW + AB;
  localparam int NB   = tcsnq_pkg::NOTE_BITS;
  localparam int BB   = tcsnq_pkg::BRIGHT_BITS;
  localparam int TB   = tcsnq_pkg::TRANSPOSE_BITS;
  localparam int SumW = NB + 2;
  localparam int PadW = tcsnq_pkg::OUT_DATA_BITS - (1 + NB + SB + 2 * BB);

  function automatic logic [LW-1:0] smooth(input logic [LW-1:0] lvl,
                                           input logic [SB-1:0] smp,
                                           input logic [AB-1:0] alpha);
    logic [LW-1:0] tgt;
    logic [LW-1:0] diff;
    logic          rise;
    logic [PW-1:0] prod;
    logic [LW-1:0] stp;
    tgt  = {smp, {FRACTION_BITS{1'b0}}};
    rise = (tgt >= lvl);
    diff = rise ? (tgt - lvl) : (lvl - tgt);
    prod = PW'(diff) * PW'(alpha) + PW'(1 << (AB - 1));
    stp  = prod[PW-1:AB];
    return rise ? (lvl + stp) : (lvl - stp);
  endfunction

  // (w - 200) * 255 / 250 as x + x / 50, with x / 50 by reciprocal 41 / 2048
  function automatic logic [BB-1:0] bright(input logic [SB-1:0] whole);
    logic [BB-1:0] x;
    logic [13:0]   p;
    x = BB'(whole - tcsnq_pkg::BRIGHT_LOW);
    p = 14'(x) * 14'd41;
    if (whole < tcsnq_pkg::BRIGHT_LOW) begin
      return '0;
    end else if (whole >= tcsnq_pkg::BRIGHT_HIGH) begin
      return '1;
    end
    return x + BB'(p[13:11]);
  endfunction

  logic [LW-1:0]           level_a_q, level_b_q;
  logic                    s1_valid_q;
  logic signed [TB-1:0]    s1_tr_q;
  logic                    out_valid_q;
  logic [tcsnq_pkg::OUT_DATA_BITS-1:0] out_data_q, out_data_d;
  logic                    out_free, s1_move, s1_free, pop;

  logic [SB-1:0]           whole_a, whole_b;
  logic [NB-1:0]           seg_note;
  logic signed [SumW-1:0]  note_sum;
  logic [NB-1:0]           note;
  logic                    note_valid;

  assign out_free     = !out_valid_q || m_axis_tready;
  assign s1_move      = s1_valid_q && out_free;
  assign s1_free      = !s1_valid_q || s1_move;
  assign pop          = item_valid_i && s1_free;
  assign item_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_a_q  <= '0;
      level_b_q  <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        level_a_q <= smooth(level_a_q, item_i.sample_a, alpha_i);
        level_b_q <= smooth(level_b_q, item_i.sample_b, alpha_i);
      end
      if (s1_free) begin
        s1_valid_q <= pop;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_tr_q <= item_i.transpose;
    end
  end

  assign whole_a = level_a_q[LW-1:FRACTION_BITS];
  assign whole_b = level_b_q[LW-1:FRACTION_BITS];

  always_comb begin
    seg_note = tcsnq_pkg::SEG_NOTE[tcsnq_pkg::SEG_COUNT-1];
    for (int i = tcsnq_pkg::SEG_COUNT - 1; i >= 0; i--) begin
      if (whole_a <= tcsnq_pkg::SEG_UPPER[i]) begin
        seg_note = tcsnq_pkg::SEG_NOTE[i];
      end
    end
    note_valid = (whole_a <= tcsnq_pkg::NOTE_LIMIT);
    note_sum   = $signed(SumW'(seg_note)) + SumW'(s1_tr_q);
    if (!note_valid) begin
      note = '0;
    end else if (note_sum < 0) begin
      note = '0;
    end else if (note_sum > $signed(SumW'({NB{1'b1}}))) begin
      note = '1;
    end else begin
      note = note_sum[NB-1:0];
    end
    out_data_d = {{PadW{1'b0}}, bright(whole_b), bright(whole_a), whole_b, note, note_valid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

>>> sv/two_channel_smooth_note_quantizer_top.sv
// tvalid rises once the input transfer has passed the queue, the level update and the output reg
// throughput: one item per cycle while m_axis_tready is high, set by the level update loop (one multiply, add)
// reset clears levels, transpose, button history and queue, and loads alpha with 655
// no clearing pass after reset; the block is ready in the first cycle
// top level: front end, queue, back end and the alpha register; uses tcsnq_pkg
module two_channel_smooth_note_quantizer_top #(
  parameter int FRACTION_BITS = tcsnq_pkg::FRACTION_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tcsnq_pkg::ALPHA_BITS-1:0]    cfg_data_i,     // smoothing_alpha
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // sample_a, sample_b, up_button, down_button
  input  logic [tcsnq_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // note_valid, note, level_b_out, brightness_a, brightness_b
  output logic [tcsnq_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);

  logic [tcsnq_pkg::ALPHA_BITS-1:0] alpha_q;
  tcsnq_pkg::item_t                 front_item, back_item;
  logic                             push, push_ready, q_valid, q_ready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= tcsnq_pkg::ALPHA_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      alpha_q <= cfg_data_i;
    end
  end

  tcsnq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .push_ready_i  (push_ready),
    .item_o        (front_item)
  );

  tcsnq_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push),
    .wr_ready_o (push_ready),
    .wr_item_i  (front_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (back_item)
  );

  tcsnq_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .alpha_i       (alpha_q),
    .item_valid_i  (q_valid),
    .item_ready_o  (q_ready),
    .item_i        (back_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_note_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[7:1] == '0))
    else $error("note nonzero while note_valid is low");

  a_bright_b_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[17:8] >= tcsnq_pkg::BRIGHT_HIGH))
      |-> (m_axis_tdata[33:26] == '1))
    else $error("brightness_b not saturated for high level");

  a_transpose_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (front_item.transpose <= $signed(7'(tcsnq_pkg::TRANSPOSE_LIMIT)) &&
              front_item.transpose >= -$signed(7'(tcsnq_pkg::TRANSPOSE_LIMIT))))
    else $error("transpose outside limit");

  a_ready_follows_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_ready) |-> (q_valid && !s_axis_tready))
    else $error("input ready while queue full");

endmodule

>>> dv/tb.sv
// self-checking testbench for two_channel_smooth_note_quantizer_top
// directed table, random phases at several alphas; a predictor checks all but pinned rows
// depends on tcsnq_pkg and the top module only
module tb;
  import tcsnq_pkg::*;

  localparam int FRAC          = FRACTION_BITS_DEF;
  localparam int LVL_BITS      = SAMPLE_BITS + FRAC;
  localparam int BRIGHT_MAX    = 2 ** BRIGHT_BITS - 1;
  localparam int NOTE_MAX      = 2 ** NOTE_BITS - 1;
  localparam int SAMPLE_MAX    = 2 ** SAMPLE_BITS - 1;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 210;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_TIME    = 2000000;

  typedef struct packed {
    logic                   note_valid;
    logic [NOTE_BITS-1:0]   note;
    logic [SAMPLE_BITS-1:0] level_b;
    logic [BRIGHT_BITS-1:0] bright_a;
    logic [BRIGHT_BITS-1:0] bright_b;
  } result_t;

  typedef enum logic [1:0] {ROW_ITEM, ROW_PINNED, ROW_ALPHA} row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [ALPHA_BITS-1:0]  alpha;
    logic [SAMPLE_BITS-1:0] a;
    logic [SAMPLE_BITS-1:0] b;
    logic                   up;
    logic                   dn;
    result_t                res;
  } row_t;

  localparam result_t NO_RES = '0;
  localparam int ROWS = 27;

  // pinned rows start from reset with alpha at 655 and zero samples, so the levels stay zero
  localparam row_t DIRECTED [ROWS] = '{
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b0, '{1'b1, 7'd60, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b1, 1'b0, '{1'b1, 7'd61, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b1, 1'b0, '{1'b1, 7'd61, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b1, '{1'b1, 7'd60, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b0, '{1'b1, 7'd60, 10'd0, 8'd0, 8'd0}},
    // both edges cancel
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b1, 1'b1, '{1'b1, 7'd60, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b0, '{1'b1, 7'd60, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b1, '{1'b1, 7'd59, 10'd0, 8'd0, 8'd0}},
    '{ROW_PINNED, 16'd0, 10'd0, 10'd0, 1'b0, 1'b0, '{1'b1, 7'd59, 10'd0, 8'd0, 8'd0}},
    '{ROW_ITEM,   16'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd682, 10'd341, 1'b1, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd341, 10'd682, 1'b0, 1'b1, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd0, 10'd1023, 1'b0, 1'b0, NO_RES},
    '{ROW_ALPHA,  16'd65535, 10'd0, 10'd0, 1'b0, 1'b0, NO_RES},
    // level a above the note range, full brightness
    '{ROW_ITEM,   16'd0, 10'd1023, 10'd1023, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd1023, 10'd0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd201, 10'd451, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd189, 10'd202, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd188, 10'd450, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd1002, 10'd200, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd1001, 10'd1001, 1'b0, 1'b0, NO_RES},
    '{ROW_ALPHA,  16'd0, 10'd0, 10'd0, 1'b0, 1'b0, NO_RES},
    // alpha zero freezes the levels
    '{ROW_ITEM,   16'd0, 10'd5, 10'd5, 1'b1, 1'b0, NO_RES},
    '{ROW_ALPHA,  16'd32768, 10'd0, 10'd0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd527, 10'd528, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd0, 10'd0, 1'b0, 1'b0, NO_RES},
    '{ROW_ITEM,   16'd0, 10'd392, 10'd391, 1'b0, 1'b1, NO_RES}
  };

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  logic [ALPHA_BITS-1:0]    cfg_data_i    = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;

  two_channel_smooth_note_quantizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [ALPHA_BITS-1:0] alpha_m = ALPHA_RESET;
  logic [LVL_BITS-1:0]   lvl_a_m = '0;
  logic [LVL_BITS-1:0]   lvl_b_m = '0;
  int                    trans_m = 0;
  logic                  up_q    = 1'b0;
  logic                  dn_q    = 1'b0;

  result_t pending [$];
  int      fail_count = 0;
  logic    pinned_on  = 1'b0;
  result_t pinned_res = '0;

  function automatic logic [LVL_BITS-1:0] ema_step(input logic [LVL_BITS-1:0] lvl,
                                                   input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] tgt;
    logic [63:0] mag;
    logic [63:0] adj;
    tgt = 64'(s) << FRAC;
    mag = (tgt >= 64'(lvl)) ? tgt - 64'(lvl) : 64'(lvl) - tgt;
    adj = (mag * 64'(alpha_m) + (64'd1 << (ALPHA_BITS - 1))) >> ALPHA_BITS;
    ema_step = (tgt >= 64'(lvl)) ? LVL_BITS'(64'(lvl) + adj) : LVL_BITS'(64'(lvl) - adj);
  endfunction

  function automatic logic [BRIGHT_BITS-1:0] light_level(input logic [SAMPLE_BITS-1:0] whole);
    int v;
    if (whole < BRIGHT_LOW) return '0;
    v = (int'(whole) - int'(BRIGHT_LOW)) * BRIGHT_MAX / (int'(BRIGHT_HIGH) - int'(BRIGHT_LOW));
    return (v > BRIGHT_MAX) ? BRIGHT_BITS'(BRIGHT_MAX) : BRIGHT_BITS'(v);
  endfunction

  function automatic result_t quantize_pass(input logic [SAMPLE_BITS-1:0] a, b,
                                            input logic up, dn);
    int                     n;
    logic [SAMPLE_BITS-1:0] wa;
    logic [SAMPLE_BITS-1:0] wb;
    result_t                r;
    trans_m = trans_m + int'(up && !up_q) - int'(dn && !dn_q);
    if (trans_m > TRANSPOSE_LIMIT) trans_m = TRANSPOSE_LIMIT;
    if (trans_m < -TRANSPOSE_LIMIT) trans_m = -TRANSPOSE_LIMIT;
    up_q    = up;
    dn_q    = dn;
    lvl_a_m = ema_step(lvl_a_m, a);
    lvl_b_m = ema_step(lvl_b_m, b);
    wa      = lvl_a_m[LVL_BITS-1 -: SAMPLE_BITS];
    wb      = lvl_b_m[LVL_BITS-1 -: SAMPLE_BITS];
    r       = '0;
    if (wa <= NOTE_LIMIT) begin
      // walk down so the lowest matching segment wins
      for (int i = SEG_COUNT - 1; i >= 0; i--) begin
        if (wa <= SEG_UPPER[i]) begin
          n = int'(SEG_NOTE[i]) + trans_m;
          if (n < 0) n = 0;
          if (n > NOTE_MAX) n = NOTE_MAX;
          r.note       = NOTE_BITS'(n);
          r.note_valid = 1'b1;
        end
      end
    end
    r.level_b  = wb;
    r.bright_a = light_level(wa);
    r.bright_b = light_level(wb);
    return r;
  endfunction

  task automatic log_fail(input string why, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%s: want valid=%0d note=%0d level_b=%0d bright_a=%0d bright_b=%0d, got valid=%0d note=%0d level_b=%0d bright_a=%0d bright_b=%0d",
               why, want.note_valid, want.note, want.level_b, want.bright_a, want.bright_b,
               got.note_valid, got.note, got.level_b, got.bright_a, got.bright_b);
  endtask

  always @(posedge clk_i) begin
    result_t r;
    result_t got;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) alpha_m = cfg_data_i;
      if (s_axis_tvalid && s_axis_tready) begin
        r = quantize_pass(s_axis_tdata[0 +: SAMPLE_BITS], s_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS],
                          s_axis_tdata[2*SAMPLE_BITS], s_axis_tdata[2*SAMPLE_BITS+1]);
        pending.push_back(pinned_on ? pinned_res : r);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.note_valid = m_axis_tdata[0];
        got.note       = m_axis_tdata[1 +: NOTE_BITS];
        got.level_b    = m_axis_tdata[1 + NOTE_BITS +: SAMPLE_BITS];
        got.bright_a   = m_axis_tdata[1 + NOTE_BITS + SAMPLE_BITS +: BRIGHT_BITS];
        got.bright_b   = m_axis_tdata[1 + NOTE_BITS + SAMPLE_BITS + BRIGHT_BITS +: BRIGHT_BITS];
        if (pending.size() == 0) begin
          log_fail("unexpected transfer", '0, got);
        end else begin
          r = pending.pop_front();
          if (got !== r) log_fail("mismatch", r, got);
        end
      end
    end
  end

  // receiver stall pattern
  logic [7:0] tick       = '0;
  int         stall_left = 0;
  int         stall_mode = 0;

  always @(negedge clk_i) begin
    tick <= tick + 8'd1;
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        m_axis_tready <= 1'b1;
      end
      1: begin
        m_axis_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        m_axis_tready <= (tick[2:0] != 3'd5);
      end
      default: begin
        m_axis_tready <= (tick[1:0] == 2'd0);
      end
    endcase
  end

  task automatic send_item(input logic [SAMPLE_BITS-1:0] a, b, input logic up, dn,
                           input logic pin, input result_t res);
    @(negedge clk_i);
    pinned_on     = pin;
    pinned_res    = res;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'({dn, up, b, a});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_alpha(input logic [ALPHA_BITS-1:0] v);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    #LIMIT_TIME;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    row_t                  row;
    logic [ALPHA_BITS-1:0] alpha_plan [PHASES];
    int                    run_left [2];
    int                    run_val [2];
    logic [SAMPLE_BITS-1:0] smp [2];
    int                    v;
    int                    btn_mode;
    int                    burst_left;
    int                    gap;
    logic                  up_d;
    logic                  dn_d;

    alpha_plan = '{16'd65535, 16'd1, 16'd0, 16'd32768, 16'd655, 16'd4096, 16'd0, 16'd0};
    alpha_plan[6] = 16'($urandom_range(0, 65535));
    alpha_plan[7] = 16'($urandom_range(2000, 20000));
    run_left   = '{0, 0};
    run_val    = '{0, 0};
    burst_left = 0;
    up_d       = 1'b0;
    dn_d       = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_ALPHA) write_alpha(row.alpha);
      else send_item(row.a, row.b, row.up, row.dn, row.kind == ROW_PINNED, row.res);
    end

    for (int p = 0; p < PHASES; p++) begin
      write_alpha(alpha_plan[p]);
      btn_mode = p % 3;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            @(negedge clk_i);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
        burst_left--;

        // each channel holds a target for a while so the level settles near it
        for (int c = 0; c < 2; c++) begin
          if (run_left[c] == 0) begin
            run_left[c] = $urandom_range(1, 60);
            case ($urandom_range(0, 7))
              0: run_val[c] = 0;
              1: run_val[c] = SAMPLE_MAX;
              2: run_val[c] = $urandom_range(int'(NOTE_LIMIT) + 1, SAMPLE_MAX);
              3: run_val[c] = $urandom_range(int'(NOTE_LIMIT) - 10, int'(NOTE_LIMIT) + 10);
              4: run_val[c] = int'(SEG_UPPER[$urandom_range(0, SEG_COUNT - 1)])
                              + $urandom_range(0, 4) - 2;
              5: run_val[c] = $urandom_range(int'(BRIGHT_LOW) - 10, int'(BRIGHT_HIGH) + 10);
              default: run_val[c] = $urandom_range(0, SAMPLE_MAX);
            endcase
          end
          run_left[c]--;
          v = run_val[c];
          if ($urandom_range(0, 3) == 0) v = v + $urandom_range(0, 6) - 3;
          if ($urandom_range(0, 11) == 0) v = $urandom_range(0, SAMPLE_MAX);
          if (v < 0) v = 0;
          if (v > SAMPLE_MAX) v = SAMPLE_MAX;
          smp[c] = SAMPLE_BITS'(v);
        end

        case (btn_mode)
          0: begin
            if ($urandom_range(0, 7) != 0) up_d = !up_d;
            dn_d = ($urandom_range(0, 15) == 0);
          end
          1: begin
            if ($urandom_range(0, 7) != 0) dn_d = !dn_d;
            up_d = ($urandom_range(0, 15) == 0);
          end
          default: begin
            up_d = 1'($urandom_range(0, 1));
            dn_d = 1'($urandom_range(0, 1));
          end
        endcase

        send_item(smp[0], smp[1], up_d, dn_d, 1'b0, '0);
      end
    end

    settle();
    if (fail_count == 0 && pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
